// ===== hw/rtl/arpc_pkg.sv =====
// arpc_pkg: shared types and constants of the arp cache table
// no dependencies; used by every module under hw/rtl

package arpc_pkg;

    // table geometry
    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    // field widths
    localparam int IP_W    = 32;
    localparam int MAC_W   = 48;
    localparam int AGE_W   = 16;
    localparam int OP_W    = 3;
    localparam int OC_W    = 2;
    localparam int USED_W  = 5;

    localparam logic [AGE_W-1:0] AGE_MAX       = '1;
    localparam logic [AGE_W-1:0] LIFETIME_INIT = 16'd300;

    // operation codes
    typedef enum logic [OP_W-1:0] {
        OP_LOOKUP = 3'd0,
        OP_LEARN  = 3'd1,
        OP_REMOVE = 3'd2,
        OP_TICK   = 3'd3,
        OP_CLEAR  = 3'd4
    } t_op;

    // learn outcome codes
    typedef enum logic [OC_W-1:0] {
        OC_EXISTS    = 2'd0,
        OC_OVERWRITE = 2'd1,
        OC_APPEND    = 2'd2,
        OC_FULL      = 2'd3
    } t_outcome;

    // sequencer states
    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } t_state;

    // one table entry
    typedef struct packed {
        logic [IP_W-1:0]  ip;
        logic [MAC_W-1:0] mac;
        logic             stat;
        logic [AGE_W-1:0] age;
    } t_entry;

    // result of the compare and age unit
    typedef struct packed {
        logic             ip_eq;
        logic             mac_eq;
        logic             expired;
        logic [AGE_W-1:0] age_next;
    } t_match;

endpackage

// ===== hw/rtl/arpc_ram.sv =====
// arpc_ram: entry store of the arp cache, one write and one registered read port
// depends on arpc_pkg

module arpc_ram (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [arpc_pkg::IDX_W-1:0] i_waddr,
    input  arpc_pkg::t_entry         i_wdata,
    input  logic                     i_re,
    input  logic [arpc_pkg::IDX_W-1:0] i_raddr,
    output arpc_pkg::t_entry         o_rdata
);

    arpc_pkg::t_entry r_mem [arpc_pkg::TABLE_DEPTH];
    arpc_pkg::t_entry r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/arpc_match.sv =====
// arpc_match: shared compare and age unit, applied to one entry per cycle
// depends on arpc_pkg

module arpc_match (
    input  arpc_pkg::t_entry                i_entry,
    input  logic [arpc_pkg::IP_W-1:0]       i_ip,
    input  logic [arpc_pkg::MAC_W-1:0]      i_mac,
    input  logic [arpc_pkg::AGE_W-1:0]      i_lifetime,
    output arpc_pkg::t_match                o_res
);

    logic [arpc_pkg::AGE_W-1:0] age_next;

    // saturating age increment
    assign age_next = (i_entry.age == arpc_pkg::AGE_MAX) ? i_entry.age
                                                         : i_entry.age + 1'b1;

    // key compares and eviction test
    always_comb begin
        o_res.ip_eq    = (i_entry.ip == i_ip);
        o_res.mac_eq   = (i_entry.mac == i_mac);
        o_res.expired  = (age_next >= i_lifetime);
        o_res.age_next = age_next;
    end

endmodule

// ===== hw/rtl/arp_cache_table_top.sv =====
// arp_cache_table_top: ordered arp cache with aging, sequencer and result registers
// depends on arpc_pkg, arpc_ram and arpc_match
//
// usage:
//   a command word (op, ip, mac, static flag) is taken at a rising edge with
//   start high and busy low. exactly one result word follows, shown for one
//   cycle with o_valid high; the receiver cannot hold it off.
//   lookup, learn, remove and tick walk the valid entries in order, one entry
//   per cycle through the single read port of the entry ram and the shared
//   compare unit; for remove and tick, kept entries are written back compacted
//   through the write port. busy stays high while the scan runs (lookup and
//   learn stop early on a match), and o_valid is high in the first cycle with
//   busy low again.
//   clear and unknown codes finish at once: o_valid in the next cycle.
//   a new command may be taken in the cycle o_valid is high.
//   the user must write entry_lifetime with i_cfg_we and i_cfg_wdata only while
//   idle; the block does not enforce it. reset empties the table (count only,
//   no clearing pass) and sets the lifetime to 300.

module arp_cache_table_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [arpc_pkg::OP_W-1:0]      i_op,
    input  logic [arpc_pkg::IP_W-1:0]      i_ip_address,
    input  logic [arpc_pkg::MAC_W-1:0]     i_mac_address,
    input  logic                           i_is_static,
    input  logic                           i_cfg_we,
    input  logic [arpc_pkg::AGE_W-1:0]     i_cfg_wdata,
    output logic                           o_valid,
    output logic                           o_hit,
    output logic [arpc_pkg::MAC_W-1:0]     o_found_mac,
    output logic [arpc_pkg::OC_W-1:0]      o_outcome,
    output logic [arpc_pkg::USED_W-1:0]    o_entries_used
);

    // control registers
    arpc_pkg::t_state               r_state, n_state;
    logic [arpc_pkg::CNT_W-1:0]     r_count, n_count;
    logic [arpc_pkg::CNT_W-1:0]     r_rd_idx, n_rd_idx;
    logic [arpc_pkg::CNT_W-1:0]     r_wr_idx, n_wr_idx;
    logic                           r_pend, n_pend;
    logic                           r_valid, n_valid;
    logic [arpc_pkg::AGE_W-1:0]     r_lifetime;

    // payload registers
    logic [arpc_pkg::OP_W-1:0]      r_op, n_op;
    logic [arpc_pkg::IP_W-1:0]      r_ip, n_ip;
    logic [arpc_pkg::MAC_W-1:0]     r_mac, n_mac;
    logic                           r_st, n_st;
    logic [arpc_pkg::IDX_W-1:0]     r_ev_idx, n_ev_idx;
    logic                           r_hit, n_hit;
    logic [arpc_pkg::MAC_W-1:0]     r_found_mac, n_found_mac;
    logic [arpc_pkg::OC_W-1:0]      r_outcome, n_outcome;

    // ram and compare unit wiring
    logic                           ram_we;
    logic [arpc_pkg::IDX_W-1:0]     ram_waddr;
    arpc_pkg::t_entry               ram_wdata;
    logic                           ram_re;
    logic [arpc_pkg::IDX_W-1:0]     ram_raddr;
    arpc_pkg::t_entry               ram_rdata;
    arpc_pkg::t_match               cmp;

    arpc_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    arpc_match u_match (
        .i_entry    (ram_rdata),
        .i_ip       (r_ip),
        .i_mac      (r_mac),
        .i_lifetime (r_lifetime),
        .o_res      (cmp)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= arpc_pkg::ST_IDLE;
            r_count    <= '0;
            r_rd_idx   <= '0;
            r_wr_idx   <= '0;
            r_pend     <= 1'b0;
            r_valid    <= 1'b0;
            r_lifetime <= arpc_pkg::LIFETIME_INIT;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_rd_idx <= n_rd_idx;
            r_wr_idx <= n_wr_idx;
            r_pend   <= n_pend;
            r_valid  <= n_valid;
            if (i_cfg_we) begin
                r_lifetime <= i_cfg_wdata;
            end
        end
    end

    // command and result payload
    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_ip        <= n_ip;
        r_mac       <= n_mac;
        r_st        <= n_st;
        r_ev_idx    <= n_ev_idx;
        r_hit       <= n_hit;
        r_found_mac <= n_found_mac;
        r_outcome   <= n_outcome;
    end

    // sequencer: next state, ram access and results
    always_comb begin
        logic finish;
        n_state     = r_state;
        n_count     = r_count;
        n_rd_idx    = r_rd_idx;
        n_wr_idx    = r_wr_idx;
        n_pend      = 1'b0;
        n_valid     = 1'b0;
        n_op        = r_op;
        n_ip        = r_ip;
        n_mac       = r_mac;
        n_st        = r_st;
        n_ev_idx    = r_ev_idx;
        n_hit       = r_hit;
        n_found_mac = r_found_mac;
        n_outcome   = r_outcome;
        ram_we      = 1'b0;
        ram_waddr   = r_wr_idx[arpc_pkg::IDX_W-1:0];
        ram_wdata   = ram_rdata;
        ram_re      = 1'b0;
        ram_raddr   = r_rd_idx[arpc_pkg::IDX_W-1:0];
        finish      = 1'b0;

        unique case (r_state)
            arpc_pkg::ST_IDLE: begin
                if (start) begin
                    n_op        = i_op;
                    n_ip        = i_ip_address;
                    n_mac       = i_mac_address;
                    n_st        = i_is_static;
                    n_rd_idx    = '0;
                    n_wr_idx    = '0;
                    n_hit       = 1'b0;
                    n_found_mac = '0;
                    n_outcome   = arpc_pkg::OC_EXISTS;
                    unique case (i_op)
                        arpc_pkg::OP_LOOKUP,
                        arpc_pkg::OP_LEARN,
                        arpc_pkg::OP_REMOVE,
                        arpc_pkg::OP_TICK: begin
                            n_state = arpc_pkg::ST_SCAN;
                        end
                        arpc_pkg::OP_CLEAR: begin
                            n_count = '0;
                            n_valid = 1'b1;
                        end
                        default: begin
                            n_valid = 1'b1;
                        end
                    endcase
                end
            end

            arpc_pkg::ST_SCAN: begin
                // issue the next read while entries remain
                if (r_rd_idx != r_count) begin
                    ram_re   = 1'b1;
                    n_rd_idx = r_rd_idx + 1'b1;
                    n_ev_idx = r_rd_idx[arpc_pkg::IDX_W-1:0];
                    n_pend   = 1'b1;
                end

                if (r_pend) begin
                    // evaluate the entry read last cycle
                    unique case (r_op)
                        arpc_pkg::OP_LOOKUP: begin
                            if (cmp.ip_eq) begin
                                ram_we        = 1'b1;
                                ram_waddr     = r_ev_idx;
                                ram_wdata.age = '0;
                                n_hit         = 1'b1;
                                n_found_mac   = ram_rdata.mac;
                                finish        = 1'b1;
                            end
                        end
                        arpc_pkg::OP_LEARN: begin
                            if (cmp.ip_eq && cmp.mac_eq) begin
                                n_outcome = arpc_pkg::OC_EXISTS;
                                finish    = 1'b1;
                            end else if (!ram_rdata.stat && (cmp.ip_eq || cmp.mac_eq)) begin
                                ram_we         = 1'b1;
                                ram_waddr      = r_ev_idx;
                                ram_wdata.ip   = r_ip;
                                ram_wdata.mac  = r_mac;
                                ram_wdata.stat = r_st;
                                n_outcome      = arpc_pkg::OC_OVERWRITE;
                                finish         = 1'b1;
                            end
                        end
                        arpc_pkg::OP_REMOVE: begin
                            // keep entries with another ip, compacted
                            if (!cmp.ip_eq) begin
                                ram_we   = 1'b1;
                                n_wr_idx = r_wr_idx + 1'b1;
                            end
                        end
                        arpc_pkg::OP_TICK: begin
                            // static entries stay as they are
                            if (ram_rdata.stat) begin
                                ram_we   = 1'b1;
                                n_wr_idx = r_wr_idx + 1'b1;
                            end else if (!cmp.expired) begin
                                ram_we        = 1'b1;
                                ram_wdata.age = cmp.age_next;
                                n_wr_idx      = r_wr_idx + 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end else if (r_rd_idx == r_count) begin
                    // scan exhausted without an early stop
                    finish = 1'b1;
                    unique case (r_op)
                        arpc_pkg::OP_LEARN: begin
                            if (r_count < arpc_pkg::CNT_W'(arpc_pkg::TABLE_DEPTH)) begin
                                ram_we         = 1'b1;
                                ram_waddr      = r_count[arpc_pkg::IDX_W-1:0];
                                ram_wdata.ip   = r_ip;
                                ram_wdata.mac  = r_mac;
                                ram_wdata.stat = r_st;
                                ram_wdata.age  = '0;
                                n_count        = r_count + 1'b1;
                                n_outcome      = arpc_pkg::OC_APPEND;
                            end else begin
                                n_outcome = arpc_pkg::OC_FULL;
                            end
                        end
                        arpc_pkg::OP_REMOVE,
                        arpc_pkg::OP_TICK: begin
                            n_count = r_wr_idx;
                        end
                        default: begin
                        end
                    endcase
                end

                if (finish) begin
                    n_state = arpc_pkg::ST_IDLE;
                    n_pend  = 1'b0;
                    n_valid = 1'b1;
                end
            end

            default: begin
                n_state = arpc_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs
    assign busy           = (r_state != arpc_pkg::ST_IDLE);
    assign o_valid        = r_valid;
    assign o_hit          = r_hit;
    assign o_found_mac    = r_found_mac;
    assign o_outcome      = r_outcome;
    assign o_entries_used = arpc_pkg::USED_W'(r_count);

`ifndef SYNTHESIS
    // a result word only appears once the sequencer is back to idle
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while busy");

    // compaction pointer never passes the read pointer
    a_wr_behind_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> (r_wr_idx <= r_rd_idx) && (r_rd_idx <= r_count))
        else $error("scan pointers out of order");

    // clear reports an empty table in the next cycle
    a_clear_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_op == arpc_pkg::OP_CLEAR))
        |=> (o_valid && (o_entries_used == '0)))
        else $error("clear did not empty the table");

    // count stays within the table
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_count <= arpc_pkg::CNT_W'(arpc_pkg::TABLE_DEPTH)))
        else $error("entry count beyond table depth");
`endif

endmodule

// ===== tb/arp_cache_table_top_tb.sv =====
// arp_cache_table_top_tb: self-checking testbench of the ordered arp cache with aging
// drives command words on the start/busy handshake and checks every result word
// against a cycle-free model of the cache kept here; depends on arpc_pkg and the top

`timescale 1ns / 1ps

module arp_cache_table_top_tb;

    import arpc_pkg::*;

    // codes outside the defined operation set
    localparam logic [OP_W-1:0] OP_UNKNOWN_FIRST = 3'd5;
    localparam logic [OP_W-1:0] OP_UNKNOWN_LAST  = 3'd7;

    localparam logic [IP_W-1:0]  IP_ONES  = '1;
    localparam logic [MAC_W-1:0] MAC_ONES = '1;
    localparam int POOL_SIZE   = 20;
    localparam int DRAIN_WAIT  = 24;
    localparam int PHASE_WORDS = 200;

    // one expected result word
    typedef struct {
        logic [OP_W-1:0]   op;
        logic              hit;
        logic [MAC_W-1:0]  mac;
        logic [OC_W-1:0]   outcome;
        logic [USED_W-1:0] used;
    } t_arp_reply;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [OP_W-1:0] i_op = '0;
    logic [IP_W-1:0] i_ip_address = '0;
    logic [MAC_W-1:0] i_mac_address = '0;
    logic i_is_static = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [AGE_W-1:0] i_cfg_wdata = '0;
    logic o_valid;
    logic o_hit;
    logic [MAC_W-1:0] o_found_mac;
    logic [OC_W-1:0] o_outcome;
    logic [USED_W-1:0] o_entries_used;

    // cache contents as the block should hold them
    t_entry cache_slot [TABLE_DEPTH];
    int cache_used = 0;
    logic [AGE_W-1:0] lifetime_now = LIFETIME_INIT;

    t_arp_reply replies_due [$];
    int fail_count = 0;

    // sender pacing
    bit sender_idles = 1'b0;
    int burst_left = 0;

    // address pools so that lookups hit and learns collide
    logic [IP_W-1:0] ip_pool [POOL_SIZE];
    logic [MAC_W-1:0] mac_pool [POOL_SIZE];

    arp_cache_table_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_op           (i_op),
        .i_ip_address   (i_ip_address),
        .i_mac_address  (i_mac_address),
        .i_is_static    (i_is_static),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_valid        (o_valid),
        .o_hit          (o_hit),
        .o_found_mac    (o_found_mac),
        .o_outcome      (o_outcome),
        .o_entries_used (o_entries_used)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // delete one entry and close the gap, order kept
    function automatic void drop_entry(int k);
        int j;
        for (j = k; j + 1 < cache_used; j++)
            cache_slot[j] = cache_slot[j + 1];
        cache_used--;
    endfunction

    // apply one command word to the cache and return the result word it yields
    function automatic t_arp_reply apply_arp_word(logic [OP_W-1:0] op, logic [IP_W-1:0] ip,
                                                  logic [MAC_W-1:0] mac, logic st);
        t_arp_reply r;
        int k;
        bit done;
        r.op = op;
        r.hit = 1'b0;
        r.mac = '0;
        r.outcome = OC_EXISTS;
        done = 1'b0;
        case (op)
            OP_LOOKUP: begin
                for (k = 0; k < cache_used && !done; k++) begin
                    if (cache_slot[k].ip == ip) begin
                        r.hit = 1'b1;
                        r.mac = cache_slot[k].mac;
                        cache_slot[k].age = '0;
                        done = 1'b1;
                    end
                end
            end
            OP_LEARN: begin
                // exact match keeps, first dynamic ip or mac match is overwritten
                for (k = 0; k < cache_used && !done; k++) begin
                    if (cache_slot[k].ip == ip && cache_slot[k].mac == mac) begin
                        r.outcome = OC_EXISTS;
                        done = 1'b1;
                    end else if (!cache_slot[k].stat &&
                                 (cache_slot[k].ip == ip || cache_slot[k].mac == mac)) begin
                        cache_slot[k].ip = ip;
                        cache_slot[k].mac = mac;
                        cache_slot[k].stat = st;
                        r.outcome = OC_OVERWRITE;
                        done = 1'b1;
                    end
                end
                if (!done) begin
                    if (cache_used < TABLE_DEPTH) begin
                        cache_slot[cache_used].ip = ip;
                        cache_slot[cache_used].mac = mac;
                        cache_slot[cache_used].stat = st;
                        cache_slot[cache_used].age = '0;
                        cache_used++;
                        r.outcome = OC_APPEND;
                    end else begin
                        r.outcome = OC_FULL;
                    end
                end
            end
            OP_REMOVE: begin
                k = 0;
                while (k < cache_used) begin
                    if (cache_slot[k].ip == ip)
                        drop_entry(k);
                    else
                        k++;
                end
            end
            OP_TICK: begin
                // static entries never age; age saturates
                k = 0;
                while (k < cache_used) begin
                    if (cache_slot[k].stat) begin
                        k++;
                    end else begin
                        if (cache_slot[k].age != AGE_MAX)
                            cache_slot[k].age = cache_slot[k].age + 1'b1;
                        if (cache_slot[k].age >= lifetime_now)
                            drop_entry(k);
                        else
                            k++;
                    end
                end
            end
            OP_CLEAR: begin
                cache_used = 0;
            end
            default: begin
            end
        endcase
        r.used = cache_used[USED_W-1:0];
        return r;
    endfunction

    // random gaps between bursts of back-to-back words
    task automatic pace_sender();
        int gap;
        if (sender_idles) begin
            if (burst_left > 0) begin
                burst_left--;
            end else begin
                gap = $urandom_range(1, DRAIN_WAIT);
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
                burst_left = $urandom_range(0, 15);
            end
        end
    endtask

    // offer one command word and wait until the block takes it
    task automatic send_word(logic [OP_W-1:0] op, logic [IP_W-1:0] ip,
                             logic [MAC_W-1:0] mac, logic st);
        start <= 1'b1;
        i_op <= op;
        i_ip_address <= ip;
        i_mac_address <= mac;
        i_is_static <= st;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        replies_due.push_back(apply_arp_word(op, ip, mac, st));
        pace_sender();
    endtask

    task automatic wait_for_replies();
        while (replies_due.size() != 0) @(posedge i_clk);
    endtask

    // lifetime is only written with the block idle
    task automatic set_lifetime(logic [AGE_W-1:0] value);
        start <= 1'b0;
        wait_for_replies();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        lifetime_now = value;
    endtask

    // compare each result word with the oldest expectation
    always @(posedge i_clk) begin : reply_check
        t_arp_reply want;
        if (i_rst_n && o_valid === 1'b1) begin
            if (replies_due.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected result word: hit %0b mac %h outcome %0d used %0d",
                             o_hit, o_found_mac, o_outcome, o_entries_used);
            end else begin
                want = replies_due.pop_front();
                if (o_hit !== want.hit || o_found_mac !== want.mac ||
                    o_outcome !== want.outcome || o_entries_used !== want.used) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display({"mismatch op %0d: expected hit %0b mac %h outcome %0d ",
                                  "used %0d, got hit %0b mac %h outcome %0d used %0d"},
                                 want.op, want.hit, want.mac, want.outcome, want.used,
                                 o_hit, o_found_mac, o_outcome, o_entries_used);
                end
            end
        end
    end

    // lookup, learn, remove and an unknown code, static protection, overwrite by mac, multi-entry remove
    task automatic test_basic_ops();
        send_word(OP_LOOKUP, '0, '0, 1'b0);
        send_word(OP_LEARN, '0, '0, 1'b0);
        send_word(OP_LEARN, IP_ONES, MAC_ONES, 1'b1);
        send_word(OP_LEARN, '0, '0, 1'b0);
        send_word(OP_LEARN, IP_ONES, 48'h1, 1'b0);
        send_word(OP_LEARN, 32'h5, '0, 1'b0);
        send_word(OP_LOOKUP, IP_ONES, '0, 1'b0);
        send_word(OP_REMOVE, IP_ONES, '0, 1'b0);
        send_word(OP_UNKNOWN_LAST, IP_ONES, MAC_ONES, 1'b1);
    endtask

    // lifetime zero evicts every dynamic entry on its first tick
    task automatic test_zero_lifetime();
        set_lifetime('0);
        send_word(OP_LEARN, 32'h9, 48'h9, 1'b1);
        send_word(OP_TICK, '0, '0, 1'b0);
    endtask

    // fill every slot, then one learn too many
    task automatic test_table_full();
        int i;
        for (i = 0; i <= TABLE_DEPTH - 1; i++)
            send_word(OP_LEARN, 32'h0A00_0000 + i, 48'h0200_0000_0000 + i, i[0]);
        send_word(OP_CLEAR, '0, '0, 1'b0);
    endtask

    task automatic refill_pools();
        int i;
        logic [63:0] w;
        for (i = 0; i < POOL_SIZE; i++) begin
            ip_pool[i] = $urandom;
            w = {$urandom, $urandom};
            mac_pool[i] = w[MAC_W-1:0];
        end
    endtask

    // one random command word; returns 1 unless the code is one the block ignores
    task automatic send_random_word(output bit counted);
        int pick;
        logic [OP_W-1:0] op;
        logic [IP_W-1:0] ip;
        logic [MAC_W-1:0] mac;
        logic [63:0] w;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            op = OP_LEARN;
        else if (pick < 70)
            op = OP_LOOKUP;
        else if (pick < 80)
            op = OP_REMOVE;
        else if (pick < 95)
            op = OP_TICK;
        else if (pick < 97)
            op = OP_CLEAR;
        else
            op = OP_W'($urandom_range(OP_UNKNOWN_FIRST, OP_UNKNOWN_LAST));
        if ($urandom_range(0, 9) == 0)
            ip = $urandom;
        else
            ip = ip_pool[$urandom_range(0, POOL_SIZE - 1)];
        if ($urandom_range(0, 9) == 0) begin
            w = {$urandom, $urandom};
            mac = w[MAC_W-1:0];
        end else begin
            mac = mac_pool[$urandom_range(0, POOL_SIZE - 1)];
        end
        counted = (op < OP_UNKNOWN_FIRST);
        send_word(op, ip, mac, $urandom_range(0, 3) == 0);
    endtask

    // phases at several lifetimes, with and without sender idling
    task automatic test_random_traffic();
        logic [AGE_W-1:0] lifetimes [6];
        int p;
        int n;
        bit counted;
        lifetimes[0] = 16'd1;
        lifetimes[1] = AGE_W'($urandom_range(2, 12));
        lifetimes[2] = AGE_MAX;
        lifetimes[3] = AGE_W'($urandom_range(3, 40));
        lifetimes[4] = AGE_W'($urandom);
        lifetimes[5] = LIFETIME_INIT;
        for (p = 0; p < 6; p++) begin
            set_lifetime(lifetimes[p]);
            refill_pools();
            sender_idles = (p != 2);
            burst_left = 0;
            n = 0;
            while (n < PHASE_WORDS) begin
                send_random_word(counted);
                if (counted)
                    n++;
            end
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        sender_idles = 1'b1;
        test_basic_ops();
        test_zero_lifetime();
        test_table_full();
        test_random_traffic();
        start <= 1'b0;
        wait_for_replies();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // hang guard
    initial begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
